// ----- rtl/tccs_pkg.sv -----
// Shared constants, codes and types for the text console cursor/scroll engine.
// No dependencies; tccs_engine, the top level and the testbench import this package.
package tccs_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CCOL_W  = $clog2(COLUMNS);
  localparam int CROW_W  = $clog2(ROWS);

  localparam int FUNC_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int RCOL_W  = 7;
  localparam int RROW_W  = 5;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = 16;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    SW_INIT   = 2'd0,
    SW_CLEAR  = 2'd1,
    SW_SCROLL = 2'd2
  } sweep_t;

  typedef struct packed {
    logic              vld;
    logic [CELL_W-1:0] entry;
    logic [RCOL_W-1:0] col;
    logic [RROW_W-1:0] row;
    logic              scrolled;
  } result_t;

endpackage

// ----- rtl/tccs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/tccs_engine.sv -----
// Sequencer for the console: cursor registers, command decode and the sweep
// unit that clears, copies and blanks the screen store. Uses tccs_pkg.
module tccs_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [tccs_pkg::FUNC_W-1:0]    func,
  input  logic [tccs_pkg::CHAR_W-1:0]    char_code,
  input  logic [tccs_pkg::RCOL_W-1:0]    read_column,
  input  logic [tccs_pkg::RROW_W-1:0]    read_row,
  input  logic [tccs_pkg::ATTR_W-1:0]    attr,
  output logic                           ram_we,
  output logic [tccs_pkg::ADDR_W-1:0]    ram_waddr,
  output logic [tccs_pkg::CELL_W-1:0]    ram_wdata,
  output logic [tccs_pkg::ADDR_W-1:0]    ram_raddr,
  input  logic [tccs_pkg::CELL_W-1:0]    ram_rdata,
  output tccs_pkg::result_t              res
);
  import tccs_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] SRC_LIM   = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
  localparam logic [CCOL_W-1:0] LAST_COL  = CCOL_W'(COLUMNS - 1);
  localparam logic [CROW_W-1:0] LAST_ROW  = CROW_W'(ROWS - 1);

  state_t              state_r, state_nxt;
  sweep_t              kind_r, kind_nxt;
  logic [ADDR_W-1:0]   ptr_r, ptr_nxt;
  logic [CELL_W-1:0]   fill_r, fill_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [ADDR_W-1:0]   pend_addr_r, pend_addr_nxt;
  logic                pend_mem_r, pend_mem_nxt;
  logic [CCOL_W-1:0]   col_r, col_nxt;
  logic [CROW_W-1:0]   row_r, row_nxt;

  logic [ADDR_W-1:0]   cur_addr;
  logic [ADDR_W-1:0]   rd_addr_in;
  logic                rd_in_range;
  logic                done_now;

  assign cur_addr    = ADDR_W'(ADDR_W'(row_r) * ROW_STEP + ADDR_W'(col_r));
  assign rd_addr_in  = ADDR_W'(ADDR_W'(read_row) * ROW_STEP + ADDR_W'(read_column));
  assign rd_in_range = (32'(read_column) < COLUMNS) && (32'(read_row) < ROWS);
  assign busy        = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    ptr_nxt       = ptr_r;
    fill_nxt      = fill_r;
    pend_vld_nxt  = 1'b0;
    pend_addr_nxt = pend_addr_r;
    pend_mem_nxt  = pend_mem_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    done_now      = 1'b0;

    ram_we    = pend_vld_r;
    ram_waddr = pend_addr_r;
    ram_wdata = pend_mem_r ? ram_rdata : fill_r;
    ram_raddr = rd_addr_in;

    res          = '0;
    res.col      = RCOL_W'(col_r);
    res.row      = RROW_W'(row_r);

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (func)
            FUNC_PUT: begin
              logic wrap;
              wrap = 1'b1;
              if (char_code != NEWLINE_CODE) begin
                ram_we    = 1'b1;
                ram_waddr = cur_addr;
                ram_wdata = {attr, char_code};
                wrap      = (col_r == LAST_COL);
                if (!wrap) begin
                  col_nxt = CCOL_W'(col_r + 1'b1);
                end
              end
              if (wrap) begin
                col_nxt = '0;
                if (row_r != LAST_ROW) begin
                  row_nxt  = CROW_W'(row_r + 1'b1);
                  done_now = 1'b1;
                end else begin
                  // bottom row: walk the store to move everything up a row
                  state_nxt = ST_SWEEP;
                  kind_nxt  = SW_SCROLL;
                  ptr_nxt   = '0;
                  fill_nxt  = BLANK_CELL;
                end
              end else begin
                done_now = 1'b1;
              end
            end
            FUNC_CLEAR: begin
              state_nxt = ST_SWEEP;
              kind_nxt  = SW_CLEAR;
              ptr_nxt   = '0;
              fill_nxt  = {attr, SPACE_CODE};
            end
            FUNC_READ: begin
              if (rd_in_range) begin
                state_nxt = ST_READ;
              end else begin
                done_now = 1'b1;
              end
            end
            default: begin
              done_now = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res.vld   = 1'b1;
        res.entry = ram_rdata;
        state_nxt = ST_IDLE;
      end
      ST_SWEEP: begin
        // scroll: read the cell one row below now, write it back next cycle; else write fill
        if (kind_r == SW_SCROLL && ptr_r < SRC_LIM) begin
          ram_raddr    = ADDR_W'(ptr_r + ROW_STEP);
          pend_mem_nxt = 1'b1;
        end else begin
          pend_mem_nxt = 1'b0;
        end
        pend_vld_nxt  = 1'b1;
        pend_addr_nxt = ptr_r;
        if (ptr_r == LAST_ADDR) begin
          state_nxt = ST_DRAIN;
        end else begin
          ptr_nxt = ADDR_W'(ptr_r + 1'b1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
        if (kind_r != SW_INIT) begin
          res.vld      = 1'b1;
          res.scrolled = (kind_r == SW_SCROLL);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (done_now) begin
      res.vld = 1'b1;
      res.col = RCOL_W'(col_nxt);
      res.row = RROW_W'(row_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_SWEEP;
      kind_r     <= SW_INIT;
      ptr_r      <= '0;
      fill_r     <= BLANK_CELL;
      pend_vld_r <= 1'b0;
      col_r      <= '0;
      row_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      kind_r     <= kind_nxt;
      ptr_r      <= ptr_nxt;
      fill_r     <= fill_nxt;
      pend_vld_r <= pend_vld_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    pend_mem_r  <= pend_mem_nxt;
  end

endmodule

// ----- rtl/text_console_cursor_scroll_top.sv -----
// Top level of the text console engine: attribute register, result register,
// sequencer and screen store. Uses tccs_pkg, tccs_engine and tccs_ram.
//
// Text console of COLUMNS x ROWS 16-bit cells (80x25 by default). A command is
// taken when start is high and busy is low; each command produces exactly one
// result, shown for a single cycle with out_valid high, in the cycle after the
// command finishes. The receiver cannot stall, so results must be captured on
// the strobe. A put character or newline without scroll finishes in the
// accepting cycle; a read goes through the registered RAM read. Clear and scroll
// walk the whole store one cell per cycle through the single RAM write port,
// ending with the final write. After reset the store is blanked by the same
// walk, so busy stays high until the walk ends; attribute writes are taken at
// any time.
module text_console_cursor_scroll_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [tccs_pkg::FUNC_W-1:0] in_func,
  input  logic [tccs_pkg::CHAR_W-1:0] in_char_code,
  input  logic [tccs_pkg::RCOL_W-1:0] in_read_column,
  input  logic [tccs_pkg::RROW_W-1:0] in_read_row,
  input  logic                        cfg_wr_en,
  input  logic [tccs_pkg::ATTR_W-1:0] cfg_wr_data,
  output logic                        out_valid,
  output logic [tccs_pkg::CELL_W-1:0] out_cell_entry,
  output logic [tccs_pkg::RCOL_W-1:0] out_cursor_column,
  output logic [tccs_pkg::RROW_W-1:0] out_cursor_row,
  output logic                        out_scrolled
);
  import tccs_pkg::*;

  logic [ATTR_W-1:0] attr_r;
  result_t           res;
  result_t           res_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_wr_en) begin
      attr_r <= cfg_wr_data;
    end
  end

  tccs_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .func        (in_func),
    .char_code   (in_char_code),
    .read_column (in_read_column),
    .read_row    (in_read_row),
    .attr        (attr_r),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .res         (res)
  );

  tccs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // hold the finished transfer for exactly one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.vld <= 1'b0;
    end else begin
      res_r.vld <= res.vld;
    end
    res_r.entry    <= res.entry;
    res_r.col      <= res.col;
    res_r.row      <= res.row;
    res_r.scrolled <= res.scrolled;
  end

  assign out_valid         = res_r.vld;
  assign out_cell_entry    = res_r.entry;
  assign out_cursor_column = res_r.col;
  assign out_cursor_row    = res_r.row;
  assign out_scrolled      = res_r.scrolled;

endmodule

// ----- dv/tb_text_console_cursor_scroll_top.sv -----
// Testbench for text_console_cursor_scroll_top: directed and random console commands,
// predicted by a shadow screen in a scoreboard class. Depends on tccs_pkg and the
// RTL top level only.
module tb_text_console_cursor_scroll_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tccs_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  // Worst case: every command walks the store plus the longest idle gap, for
  // about 800 commands, plus the blanking walk after reset; taken three times over.
  localparam int LIMIT_CYCLES = 6_000_000;
  localparam int CHUNK_ITEMS  = 75;
  localparam int CHUNKS       = 10;

  typedef struct packed {
    logic [CELL_W-1:0] entry;
    logic [RCOL_W-1:0] col;
    logic [RROW_W-1:0] row;
    logic              scrolled;
  } console_result_t;

  class console_shadow;
    logic [CELL_W-1:0] screen [CELLS];
    int                cur_col;
    int                cur_row;
    logic [ATTR_W-1:0] attr;
    console_result_t   pending[$];
    int                errors;

    function new();
      foreach (screen[i]) screen[i] = BLANK_CELL;
      cur_col = 0;
      cur_row = 0;
      attr    = ATTR_RESET;
      errors  = 0;
    endfunction

    function void set_attribute(logic [ATTR_W-1:0] value);
      attr = value;
    endfunction

    // Move to the start of the next row, or scroll up on the bottom row.
    function logic advance_line();
      cur_col = 0;
      if (cur_row < ROWS - 1) begin
        cur_row++;
        return 1'b0;
      end
      for (int i = 0; i < COLUMNS * (ROWS - 1); i++) screen[i] = screen[i + COLUMNS];
      for (int i = 0; i < COLUMNS; i++) screen[COLUMNS * (ROWS - 1) + i] = BLANK_CELL;
      return 1'b1;
    endfunction

    function void note_command(logic [FUNC_W-1:0] func, logic [CHAR_W-1:0] ch,
                               logic [RCOL_W-1:0] rcol, logic [RROW_W-1:0] rrow);
      console_result_t res;
      res.entry    = '0;
      res.scrolled = 1'b0;
      case (func)
        FUNC_PUT: begin
          if (ch == NEWLINE_CODE) begin
            res.scrolled = advance_line();
          end else begin
            screen[cur_row * COLUMNS + cur_col] = {attr, ch};
            cur_col++;
            if (cur_col >= COLUMNS) res.scrolled = advance_line();
          end
        end
        FUNC_CLEAR: begin
          foreach (screen[i]) screen[i] = {attr, SPACE_CODE};
        end
        FUNC_READ: begin
          if (rcol < COLUMNS && rrow < ROWS) res.entry = screen[rrow * COLUMNS + rcol];
        end
        default: ;
      endcase
      res.col = RCOL_W'(cur_col);
      res.row = RROW_W'(cur_row);
      pending.push_back(res);
    endfunction

    function void check_result(console_result_t got);
      console_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: result with no command pending: %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (exp.entry !== got.entry) begin
        $display("%0t: cell_entry expected %h, got %h", $time, exp.entry, got.entry);
        errors++;
      end
      if (exp.col !== got.col) begin
        $display("%0t: cursor_column expected %0d, got %0d", $time, exp.col, got.col);
        errors++;
      end
      if (exp.row !== got.row) begin
        $display("%0t: cursor_row expected %0d, got %0d", $time, exp.row, got.row);
        errors++;
      end
      if (exp.scrolled !== got.scrolled) begin
        $display("%0t: scrolled expected %b, got %b", $time, exp.scrolled, got.scrolled);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [FUNC_W-1:0] in_func = '0;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic [RCOL_W-1:0] in_read_column = '0;
  logic [RROW_W-1:0] in_read_row = '0;
  logic              cfg_wr_en = 1'b0;
  logic [ATTR_W-1:0] cfg_wr_data = '0;
  logic              out_valid;
  logic [CELL_W-1:0] out_cell_entry;
  logic [RCOL_W-1:0] out_cursor_column;
  logic [RROW_W-1:0] out_cursor_row;
  logic              out_scrolled;

  console_shadow shadow = new();
  int unsigned   cycles = 0;

  text_console_cursor_scroll_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_char_code     (in_char_code),
    .in_read_column   (in_read_column),
    .in_read_row      (in_read_row),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_cell_entry   (out_cell_entry),
    .out_cursor_column(out_cursor_column),
    .out_cursor_row   (out_cursor_row),
    .out_scrolled     (out_scrolled)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      shadow.check_result({out_cell_entry, out_cursor_column, out_cursor_row, out_scrolled});
  end

  // Present one command and hold it until the transfer; start stays high afterwards.
  task automatic send_command(logic [FUNC_W-1:0] func, logic [CHAR_W-1:0] ch,
                              logic [RCOL_W-1:0] rcol, logic [RROW_W-1:0] rrow);
    in_func        <= func;
    in_char_code   <= ch;
    in_read_column <= rcol;
    in_read_row    <= rrow;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
    shadow.note_command(func, ch, rcol, rrow);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drain all results, let the block settle, then write the attribute.
  task automatic write_attribute(logic [ATTR_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (shadow.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    shadow.set_attribute(value);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 8'($urandom);
  endtask

  task automatic random_command();
    int                pick;
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] ch;
    logic [RCOL_W-1:0] rcol;
    logic [RROW_W-1:0] rrow;
    pick = $urandom_range(999);
    ch   = 8'($urandom);
    rcol = 7'($urandom);
    rrow = 5'($urandom);
    if (pick < 15) begin
      func = FUNC_CLEAR;
    end else if (pick < 35) begin
      func = FUNC_NONE;
    end else if (pick < 190) begin
      func = FUNC_READ;
      // Mostly in range, biased toward the rows being written.
      if ($urandom_range(9) != 0) begin
        rcol = 7'($urandom_range(COLUMNS - 1));
        if ($urandom_range(1))
          rrow = 5'(shadow.cur_row - $urandom_range(shadow.cur_row > 0 ? 1 : 0));
        else
          rrow = 5'($urandom_range(ROWS - 1));
      end
    end else begin
      func = FUNC_PUT;
      pick = $urandom_range(99);
      if (pick < 9)       ch = NEWLINE_CODE;
      else if (pick < 20) ch = 8'($urandom);
      else                ch = 8'($urandom_range(8'h7E, 8'h20));
    end
    send_command(func, ch, rcol, rrow);
  endtask

  initial begin
    logic [ATTR_W-1:0] attr_value;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    write_attribute(8'h1F);

    // Directed: char extremes, reads in and out of range, newline, clear, unused func.
    send_command(FUNC_PUT, 8'h41, 7'd0, 5'd0);
    send_command(FUNC_PUT, 8'h00, 7'd127, 5'd31);
    send_command(FUNC_PUT, 8'hFF, 7'd5, 5'd3);
    send_command(FUNC_READ, 8'hFF, 7'd0, 5'd0);
    send_command(FUNC_READ, 8'h00, 7'd1, 5'd0);
    send_command(FUNC_READ, 8'h55, 7'd2, 5'd0);
    send_command(FUNC_PUT, NEWLINE_CODE, 7'd0, 5'd0);
    send_command(FUNC_PUT, 8'h42, 7'd0, 5'd0);
    send_command(FUNC_READ, 8'h00, 7'd0, 5'd1);
    send_command(FUNC_READ, 8'h00, 7'd79, 5'd24);
    send_command(FUNC_READ, 8'h00, 7'd80, 5'd0);
    send_command(FUNC_READ, 8'h00, 7'd0, 5'd25);
    send_command(FUNC_READ, 8'h00, 7'd127, 5'd31);
    send_command(FUNC_NONE, 8'h00, 7'd0, 5'd0);
    send_command(FUNC_CLEAR, 8'h00, 7'd0, 5'd0);
    send_command(FUNC_READ, 8'h00, 7'd0, 5'd0);
    send_command(FUNC_READ, 8'h00, 7'd79, 5'd24);
    send_command(FUNC_PUT, 8'h43, 7'd0, 5'd0);
    send_command(FUNC_READ, 8'h00, 7'd1, 5'd1);
    send_command(FUNC_NONE, 8'hFF, 7'd127, 5'd31);
    write_attribute(8'hA5);
    send_command(FUNC_PUT, 8'h7E, 7'd0, 5'd0);
    send_command(FUNC_READ, 8'h00, 7'd2, 5'd1);

    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      case (chunk)
        0:       attr_value = 8'h00;
        1:       attr_value = 8'hFF;
        2:       attr_value = ATTR_RESET;
        default: attr_value = 8'($urandom);
      endcase
      write_attribute(attr_value);
      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        // Chunk 4 runs back to back with no idling.
        if (chunk != 4 && $urandom_range(99) < 34) idle_cycles($urandom_range(1, 6));
        random_command();
      end
    end
    start <= 1'b0;

    while (shadow.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (shadow.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tccs_pkg.sv
rtl/tccs_ram.sv
rtl/tccs_engine.sv
rtl/text_console_cursor_scroll_top.sv
dv/tb_text_console_cursor_scroll_top.sv
